>>> src/grid_ray_march_column_core_defines.svh
// ----------------------------------------------------------------------------
// Grid ray march column core: assertion macros
// Property shorthands used by the top level, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_MARCH_COLUMN_CORE_DEFINES_SVH
`define GRID_RAY_MARCH_COLUMN_CORE_DEFINES_SVH

// Same-cycle implication.
`define GRMC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GRMC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/grmc_pkg.sv
// ----------------------------------------------------------------------------
// Grid ray march column package
// Sizes, field layout, sine table and shared request types.
// ----------------------------------------------------------------------------
`default_nettype none

package grmc_pkg;

  localparam int MAP_W       = 16;
  localparam int MAP_H       = 16;
  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 64;
  localparam int ANGLE_STEPS = 1024;

  localparam int MAP_CELLS = MAP_W * MAP_H;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int SCREEN_W_LOG = $clog2(SCREEN_W);

  // field widths
  localparam int KIND_W   = 1;
  localparam int CELL_X_W = 4;
  localparam int CELL_Y_W = 4;
  localparam int CELL_W   = 8;
  localparam int COL_W    = 7;
  localparam int PPOS_W   = 12;
  localparam int ANG_W    = $clog2(ANGLE_STEPS);
  localparam int FOV_W    = 9;
  localparam int MAXD_W   = 16;
  localparam int STEP_W   = 8;
  localparam int CORR_W   = 16;
  localparam int TOP_W    = 6;
  localparam int BOT_W    = 7;

  // input tdata layout, lowest bit first
  localparam int IN_X_LSB   = 0;
  localparam int IN_Y_LSB   = IN_X_LSB + CELL_X_W;
  localparam int IN_V_LSB   = IN_Y_LSB + CELL_Y_W;
  localparam int IN_COL_LSB = IN_V_LSB + CELL_W;
  localparam int IN_PX_LSB  = IN_COL_LSB + COL_W;
  localparam int IN_PY_LSB  = IN_PX_LSB + PPOS_W;
  localparam int IN_PA_LSB  = IN_PY_LSB + PPOS_W;
  localparam int IN_USED_W  = IN_PA_LSB + ANG_W;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int OUT_USED_W = COL_W + CELL_W + CORR_W + TOP_W + BOT_W + 1;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // configuration port
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = MAXD_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FOV  = 2'd0,
    REG_MAXD = 2'd1,
    REG_STEP = 2'd2
  } reg_idx_t;

  localparam logic [FOV_W-1:0]  FOV_RESET  = FOV_W'(171);
  localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(5120);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(13);

  // fixed point
  localparam int SIN_FRAC   = 14;
  localparam int SIN_MAG_W  = SIN_FRAC + 1;
  localparam int SIN_W      = SIN_MAG_W + 1;
  localparam int SIN_ONE    = 1 << SIN_FRAC;
  localparam int CELL_SHIFT = 8 + SIN_FRAC;
  localparam int QTR        = ANGLE_STEPS / 4;
  localparam int QTR_W      = ANG_W - 2;

  localparam int MAP_SPAN    = (MAP_W > MAP_H ? MAP_W : MAP_H) << CELL_SHIFT;
  localparam int PLAYER_SPAN = 1 << (PPOS_W + SIN_FRAC);
  localparam int POS_W   = $clog2(MAP_SPAN > PLAYER_SPAN ? MAP_SPAN : PLAYER_SPAN) + 2;
  localparam int CIDX_W  = POS_W - 1 - CELL_SHIFT;
  localparam int DELTA_W = SIN_W + STEP_W + 1;
  localparam int DIST_W  = MAXD_W + 1;
  localparam int PROD_W  = DIST_W + SIN_MAG_W;

  localparam int ROUND_HALF = 1 << (SIN_FRAC - 1);
  localparam int NEAR_BIAS  = 26;
  localparam int GLYPH_DIST = 768;
  localparam int GLYPH_TYPE = 2;
  localparam int OUT_TYPE   = 1;
  localparam int HALF_H     = SCREEN_H / 2;

  localparam int DIVIDEND  = SCREEN_H * 128;
  localparam int QUO_W     = $clog2(DIVIDEND + 1);
  localparam int DIVISOR_W = CORR_W + 1;
  localparam int DCNT_W    = $clog2(QUO_W + 1);
  localparam int H_W       = $clog2(SCREEN_H + 1);

  localparam longint SIN_A = 51472;
  localparam longint SIN_B = 21024;
  localparam longint SIN_C = 2320;

  typedef logic [SIN_MAG_W-1:0] sin_tab_t [QTR];

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint z, z2, inner, mid, s, s14;
    for (int i = 0; i < QTR; i++) begin
      z     = (longint'(4 * i) * 32768) / ANGLE_STEPS;
      z2    = (z * z) >> 15;
      inner = SIN_B - ((z2 * SIN_C) >> 15);
      mid   = SIN_A - ((z2 * inner) >> 15);
      s     = (z * mid) >> 15;
      s14   = (s + 1) >> 1;
      if (s14 > SIN_ONE) s14 = SIN_ONE;
      tab[i] = SIN_MAG_W'(s14);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic signed [SIN_W-1:0] sin_q14(input logic [ANG_W-1:0] a);
    logic [1:0]           quad;
    logic [QTR_W-1:0]     r;
    logic [QTR_W:0]       idx;
    logic [SIN_MAG_W-1:0] mag;
    quad = a[ANG_W-1 -: 2];
    r    = a[QTR_W-1:0];
    idx  = quad[0] ? ((QTR_W+1)'(QTR) - {1'b0, r}) : {1'b0, r};
    mag  = idx[QTR_W] ? SIN_MAG_W'(SIN_ONE) : SIN_TAB[idx[QTR_W-1:0]];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [SIN_W-1:0] cos_q14(input logic [ANG_W-1:0] a);
    return sin_q14(a + ANG_W'(QTR));
  endfunction

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } map_req_t;

  typedef struct packed {
    logic              clearing;
    logic [CELL_W-1:0] rd_data;
  } map_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> src/grmc_map_ram.sv
// ----------------------------------------------------------------------------
// Grid ray march map memory
// Single-port cell store, registered read, zero sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module grmc_map_ram (
  input  logic               clk,
  input  logic               rst,
  input  grmc_pkg::map_req_t req,
  output grmc_pkg::map_rsp_t rsp
);
  import grmc_pkg::*;

  logic [CELL_W-1:0] mem [MAP_CELLS];
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic [CELL_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MAP_CELLS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) rd_data <= mem[req.addr];
  end

  assign rsp.clearing = clearing;
  assign rsp.rd_data  = rd_data;

endmodule

`default_nettype wire

>>> src/grmc_divider.sv
// ----------------------------------------------------------------------------
// Grid ray march height divider
// Restoring divider, constant dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grmc_divider (
  input  logic               clk,
  input  logic               rst,
  input  grmc_pkg::div_req_t req,
  output grmc_pkg::div_rsp_t rsp
);
  import grmc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DCNT_W-1:0]    cnt;
  logic [QUO_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign shifted = {rem, quo[QUO_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= QUO_W'(DIVIDEND);
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

>>> src/grid_ray_march_column_core.sv
// ----------------------------------------------------------------------------
// Grid ray march column core
// Casts one ray per column request through a 16 by 16 cell map.
//
//   port group   dir  carries
//   s_axis_*     in   map write (tuser 0) or column cast (tuser 1)
//   m_axis_*     out  one wall strip result per column cast
//   cfg_*        in   field of view, march limit, step length
//
// A map write leaves the core idle and ready for the next request. A column cast
// passes through angle, trig, delta, march, scale, round, start, divider wait and emit;
// the march takes steps, one map read each while inside the map, until a hit,
// leaving the map or the march limit. The next request is taken once the result is
// loaded for m_axis. After reset a sweep zeroes the map; no request is taken meanwhile.
// One result may wait on m_axis; a second waits in the core and holds off requests.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_ray_march_column_core_defines.svh"

module grid_ray_march_column_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cell_x, cell_y, cell_value, column, player_x, player_y, player_angle
  input  logic [grmc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind
  input  logic [grmc_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // column_out, wall_type, corrected_distance, wall_top, wall_bottom, wall_glyph
  output logic [grmc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_wr_en,
  input  logic [grmc_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [grmc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import grmc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ANGLE = 10'b0000000010,
    S_TRIG  = 10'b0000000100,
    S_DELTA = 10'b0000001000,
    S_MARCH = 10'b0000010000,
    S_SCALE = 10'b0000100000,
    S_ROUND = 10'b0001000000,
    S_START = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state;

  logic [FOV_W-1:0]  field_of_view;
  logic [MAXD_W-1:0] march_limit;
  logic [STEP_W-1:0] step_size;

  map_req_t map_req;
  map_rsp_t map_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // request fields
  logic                in_accept;
  logic                in_cast;
  logic [CELL_X_W-1:0] in_cell_x;
  logic [CELL_Y_W-1:0] in_cell_y;
  logic [CELL_W-1:0]   in_cell_value;
  logic                write_ok;
  logic [ADDR_W-1:0]   write_addr;

  // cast payload
  logic [COL_W-1:0]  col;
  logic [PPOS_W-1:0] px;
  logic [PPOS_W-1:0] py;
  logic [ANG_W-1:0]  pa;
  logic [ANG_W-1:0]  rel_mod;
  logic [ANG_W-1:0]  ray;
  logic [FOV_W+COL_W-1:0] fov_prod;
  logic [ANG_W-1:0]  rel_calc;
  logic signed [SIN_W-1:0] cos_ray;
  logic signed [SIN_W-1:0] sin_ray;
  logic signed [SIN_W-1:0] cos_rel;
  logic [STEP_W-1:0] step_eff;
  logic signed [DELTA_W-1:0] dx_calc;
  logic signed [DELTA_W-1:0] dy_calc;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;

  // march
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] ny;
  logic [CIDX_W-1:0] nx_cell;
  logic [CIDX_W-1:0] ny_cell;
  logic              n_inside;
  logic [ADDR_W-1:0] march_addr;
  logic [DIST_W-1:0] travel;
  logic [DIST_W-1:0] ndist;
  logic [DIST_W-1:0] chk_dist;
  logic              pend;
  logic              hit_now;
  logic              can_step;
  logic              march_rd;

  // result
  logic [CELL_W-1:0] wtype;
  logic [DIST_W-1:0] raw;
  logic [PROD_W-1:0] prod_calc;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   rnd;
  logic [CORR_W-1:0] corr;
  logic              cos_rel_pos;
  logic [H_W-1:0]    h;
  logic              emit_load;

  logic              out_valid;
  logic [COL_W-1:0]  out_col;
  logic [CELL_W-1:0] out_type;
  logic [CORR_W-1:0] out_corr;
  logic [TOP_W-1:0]  out_top;
  logic [BOT_W-1:0]  out_bottom;
  logic              out_glyph;

  grmc_map_ram u_map (
    .clk (clk),
    .rst (rst),
    .req (map_req),
    .rsp (map_rsp)
  );

  grmc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      field_of_view <= FOV_RESET;
      march_limit   <= MAXD_RESET;
      step_size     <= STEP_RESET;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_FOV:  field_of_view <= cfg_wdata[FOV_W-1:0];
        REG_MAXD: march_limit   <= cfg_wdata[MAXD_W-1:0];
        REG_STEP: step_size     <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // request side
  assign s_axis_tready = (state == S_IDLE) && !map_rsp.clearing;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_cast       = s_axis_tuser[0];
  assign in_cell_x     = s_axis_tdata[IN_X_LSB +: CELL_X_W];
  assign in_cell_y     = s_axis_tdata[IN_Y_LSB +: CELL_Y_W];
  assign in_cell_value = s_axis_tdata[IN_V_LSB +: CELL_W];
  assign write_ok      = (int'(in_cell_x) < MAP_W) && (int'(in_cell_y) < MAP_H);
  assign write_addr    = ADDR_W'(int'(in_cell_y) * MAP_W + int'(in_cell_x));

  // angle and step set-up
  assign fov_prod = field_of_view * col;
  assign rel_calc = ANG_W'(fov_prod >> SCREEN_W_LOG) - ANG_W'(field_of_view >> 1);
  assign dx_calc  = cos_ray * $signed({1'b0, step_eff});
  assign dy_calc  = sin_ray * $signed({1'b0, step_eff});

  // march step
  assign nx       = pos_x + {{(POS_W-DELTA_W){dx[DELTA_W-1]}}, dx};
  assign ny       = pos_y + {{(POS_W-DELTA_W){dy[DELTA_W-1]}}, dy};
  assign nx_cell  = nx[POS_W-2:CELL_SHIFT];
  assign ny_cell  = ny[POS_W-2:CELL_SHIFT];
  assign n_inside = !nx[POS_W-1] && !ny[POS_W-1] &&
                    (nx_cell < CIDX_W'(MAP_W)) && (ny_cell < CIDX_W'(MAP_H));
  assign march_addr = ADDR_W'(int'(ny_cell) * MAP_W + int'(nx_cell));
  assign ndist    = travel + DIST_W'(step_eff);
  assign hit_now  = pend && (map_rsp.rd_data != '0);
  assign can_step = travel < DIST_W'(march_limit);
  assign march_rd = (state == S_MARCH) && !hit_now && can_step && n_inside;

  assign map_req.wr_en = in_accept && !in_cast && write_ok;
  assign map_req.rd_en = march_rd;
  assign map_req.addr  = march_rd ? march_addr : write_addr;
  assign map_req.wdata = in_cell_value;

  // distance correction and height
  assign prod_calc = raw * cos_rel[SIN_MAG_W-1:0];
  assign rnd       = {1'b0, prod} + (PROD_W+1)'(ROUND_HALF);

  assign div_req.start   = (state == S_START);
  assign div_req.divisor = DIVISOR_W'(corr) + DIVISOR_W'(NEAR_BIAS);

  assign emit_load = (state == S_EMIT) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept && in_cast) state <= S_ANGLE;
        end
        S_ANGLE: state <= S_TRIG;
        S_TRIG:  state <= S_DELTA;
        S_DELTA: begin
          pend  <= 1'b0;
          state <= S_MARCH;
        end
        S_MARCH: begin
          pend <= march_rd;
          if (hit_now || !can_step || !n_inside) state <= S_SCALE;
        end
        S_SCALE: state <= S_ROUND;
        S_ROUND: state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col <= s_axis_tdata[IN_COL_LSB +: COL_W];
        px  <= s_axis_tdata[IN_PX_LSB +: PPOS_W];
        py  <= s_axis_tdata[IN_PY_LSB +: PPOS_W];
        pa  <= s_axis_tdata[IN_PA_LSB +: ANG_W];
      end
      S_ANGLE: begin
        rel_mod <= rel_calc;
        ray     <= pa + rel_calc;
      end
      S_TRIG: begin
        cos_ray  <= cos_q14(ray);
        sin_ray  <= sin_q14(ray);
        cos_rel  <= cos_q14(rel_mod);
        step_eff <= (step_size == '0) ? STEP_W'(1) : step_size;
      end
      S_DELTA: begin
        dx     <= dx_calc;
        dy     <= dy_calc;
        pos_x  <= POS_W'(px) << SIN_FRAC;
        pos_y  <= POS_W'(py) << SIN_FRAC;
        travel <= '0;
      end
      S_MARCH: begin
        if (hit_now) begin
          wtype <= map_rsp.rd_data;
          raw   <= chk_dist;
        end else if (can_step) begin
          pos_x    <= nx;
          pos_y    <= ny;
          travel   <= ndist;
          chk_dist <= ndist;
          if (!n_inside) begin
            wtype <= CELL_W'(OUT_TYPE);
            raw   <= ndist;
          end
        end else begin
          wtype <= '0;
          raw   <= DIST_W'(march_limit);
        end
      end
      S_SCALE: begin
        prod        <= prod_calc;
        cos_rel_pos <= !cos_rel[SIN_W-1] && (cos_rel != '0);
      end
      S_ROUND: begin
        if (!cos_rel_pos) begin
          corr <= '0;
        end else if (rnd[PROD_W:SIN_FRAC] > (PROD_W+1-SIN_FRAC)'({CORR_W{1'b1}})) begin
          corr <= '1;
        end else begin
          corr <= rnd[SIN_FRAC +: CORR_W];
        end
      end
      S_DIV: begin
        if (div_rsp.quotient > QUO_W'(SCREEN_H)) h <= H_W'(SCREEN_H);
        else h <= div_rsp.quotient[H_W-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      if (emit_load) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_col    <= col;
      out_type   <= wtype;
      out_corr   <= corr;
      out_top    <= TOP_W'(HALF_H) - TOP_W'(h >> 1);
      out_bottom <= BOT_W'(HALF_H) + BOT_W'(h >> 1);
      out_glyph  <= (wtype == CELL_W'(GLYPH_TYPE)) && (corr >= CORR_W'(GLYPH_DIST));
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
                          out_glyph, out_bottom, out_top, out_corr, out_type, out_col};

  `GRMC_ASSERT_SAME(a_div_done_in_wait, div_rsp.done, state == S_DIV, "divider done outside wait")
  `GRMC_ASSERT_NEXT(a_read_consumed, map_req.rd_en, (state == S_MARCH) && pend, "map read not checked")
  `GRMC_ASSERT_SAME(a_dist_bound, (state == S_MARCH) && pend, chk_dist < (DIST_W'(march_limit) + DIST_W'(step_eff)), "march overran limit")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Grid ray march column core: testbench
// Streams map writes and column casts into the core under several register
// settings and idle patterns, predicts every wall strip from its own map copy
// and march, and compares each strip field by field as it leaves the core.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import grmc_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_WRITE = 1'b0;
  localparam logic [KIND_W-1:0]    KIND_CAST  = 1'b1;
  localparam logic [REG_IDX_W-1:0] REG_NONE   = 2'd3;
  localparam int SETTLE      = 40;
  localparam int QUIET_LIMIT = 100000;
  localparam int MAX_SHOWN   = 10;
  localparam int BLOCKS      = 9;
  localparam int BLOCK_ITEMS = 128;
  localparam longint CORR_MAX = (longint'(1) << CORR_W) - 1;
  localparam logic [IN_DATA_W-1:0] USED_MASK = (IN_DATA_W'(1) << IN_USED_W) - 1;

  typedef struct packed {
    logic              glyph;
    logic [BOT_W-1:0]  bottom;
    logic [TOP_W-1:0]  top;
    logic [CORR_W-1:0] corr_dist;
    logic [CELL_W-1:0] wall_type;
    logic [COL_W-1:0]  column;
  } strip_t;

  class strip_ledger;
    logic [CELL_W-1:0] cells [MAP_CELLS];
    logic [FOV_W-1:0]  fov;
    logic [MAXD_W-1:0] maxd;
    logic [STEP_W-1:0] step_len;
    strip_t strips_due[$];
    int mismatches, n_writes, n_casts, n_walls, n_glyphs, n_outside, n_open;

    function new();
      foreach (cells[i]) cells[i] = '0;
      fov      = FOV_RESET;
      maxd     = MAXD_RESET;
      step_len = STEP_RESET;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_FOV:  fov = v[FOV_W-1:0];
        REG_MAXD: maxd = v[MAXD_W-1:0];
        REG_STEP: step_len = v[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // Q1.14 sine from the quarter-turn polynomial
    function int ray_sine(logic [ANG_W-1:0] a);
      longint t, z, z2, inner, mid, s, s14;
      t = 4 * longint'(a[QTR_W-1:0]);
      if (a[ANG_W-2]) t = ANGLE_STEPS - t;
      z     = (t * 32768) / ANGLE_STEPS;
      z2    = (z * z) >> 15;
      inner = SIN_B - ((z2 * SIN_C) >> 15);
      mid   = SIN_A - ((z2 * inner) >> 15);
      s     = (z * mid) >> 15;
      s14   = (s + 1) >> 1;
      if (s14 > SIN_ONE) s14 = SIN_ONE;
      return a[ANG_W-1] ? -int'(s14) : int'(s14);
    endfunction

    function strip_t march_column(logic [COL_W-1:0] col, logic [PPOS_W-1:0] px0,
                                  logic [PPOS_W-1:0] py0, logic [ANG_W-1:0] facing);
      strip_t r;
      logic [ANG_W-1:0]  offset, ray;
      logic [CELL_W-1:0] wall;
      int rel, stride, travel, raw, cx, cy, cosr, h;
      longint px, py, dx, dy, corr;
      bit hit, left_map;
      rel    = (int'(fov) * int'(col)) / SCREEN_W - int'(fov) / 2;
      offset = ANG_W'(rel);
      ray    = facing + offset;
      stride = (step_len == '0) ? 1 : int'(step_len);
      dx = longint'(ray_sine(ray + ANG_W'(QTR))) * stride;
      dy = longint'(ray_sine(ray)) * stride;
      px = longint'(px0) << SIN_FRAC;
      py = longint'(py0) << SIN_FRAC;
      travel = 0;
      hit = 1'b0;
      left_map = 1'b0;
      wall = '0;
      // step first, then test the cell entered
      while (travel < int'(maxd) && !hit) begin
        px += dx;
        py += dy;
        travel += stride;
        if (px < 0 || py < 0 || (px >>> CELL_SHIFT) >= MAP_W ||
            (py >>> CELL_SHIFT) >= MAP_H) begin
          hit = 1'b1;
          left_map = 1'b1;
          wall = CELL_W'(OUT_TYPE);
        end else begin
          cx = int'(px >>> CELL_SHIFT);
          cy = int'(py >>> CELL_SHIFT);
          if (cells[cy * MAP_W + cx] != '0) begin
            hit = 1'b1;
            wall = cells[cy * MAP_W + cx];
          end
        end
      end
      raw  = hit ? travel : int'(maxd);
      cosr = ray_sine(offset + ANG_W'(QTR));
      if (cosr <= 0) begin
        corr = 0;
      end else begin
        corr = (longint'(raw) * cosr + ROUND_HALF) >>> SIN_FRAC;
        if (corr > CORR_MAX) corr = CORR_MAX;
      end
      h = int'(longint'(DIVIDEND) / (corr + NEAR_BIAS));
      if (h > SCREEN_H) h = SCREEN_H;
      r.column    = col;
      r.wall_type = wall;
      r.corr_dist = CORR_W'(corr);
      r.top       = TOP_W'(HALF_H - h / 2);
      r.bottom    = BOT_W'(HALF_H + h / 2);
      r.glyph     = (wall == GLYPH_TYPE && corr >= GLYPH_DIST);
      if (!hit) n_open++;
      else if (left_map) n_outside++;
      else n_walls++;
      if (r.glyph) n_glyphs++;
      return r;
    endfunction

    function void take_request(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] d);
      int x, y;
      if (kind == KIND_WRITE) begin
        x = int'(d[IN_X_LSB +: CELL_X_W]);
        y = int'(d[IN_Y_LSB +: CELL_Y_W]);
        if (x < MAP_W && y < MAP_H) cells[y * MAP_W + x] = d[IN_V_LSB +: CELL_W];
        n_writes++;
      end else begin
        strips_due.push_back(march_column(d[IN_COL_LSB +: COL_W], d[IN_PX_LSB +: PPOS_W],
                                          d[IN_PY_LSB +: PPOS_W], d[IN_PA_LSB +: ANG_W]));
        n_casts++;
      end
    endfunction

    function void check_strip(logic [OUT_DATA_W-1:0] d);
      strip_t got, want;
      got = d[OUT_USED_W-1:0];
      if (strips_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected strip: col %0d type %0d dist %0d", got.column,
                   got.wall_type, got.corr_dist);
        return;
      end
      want = strips_due.pop_front();
      if (got.column !== want.column || got.wall_type !== want.wall_type ||
          got.corr_dist !== want.corr_dist || got.top !== want.top ||
          got.bottom !== want.bottom || got.glyph !== want.glyph) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"strip mismatch: expected col %0d type %0d dist %0d rows %0d-%0d ",
                    "glyph %0d, got col %0d type %0d dist %0d rows %0d-%0d glyph %0d"},
                   want.column, want.wall_type, want.corr_dist, want.top, want.bottom,
                   want.glyph, got.column, got.wall_type, got.corr_dist, got.top,
                   got.bottom, got.glyph);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  strip_ledger board;
  int src_idle_pct   = 9;
  int sink_stall_pct = 70;
  int n_settings     = 0;

  grid_ray_march_column_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [IN_DATA_W-1:0] make_write(input logic [CELL_X_W-1:0] x,
                                                      input logic [CELL_Y_W-1:0] y,
                                                      input logic [CELL_W-1:0] v);
    logic [IN_DATA_W-1:0] d;
    d = {$urandom, $urandom} & USED_MASK;
    d[IN_X_LSB +: CELL_X_W] = x;
    d[IN_Y_LSB +: CELL_Y_W] = y;
    d[IN_V_LSB +: CELL_W]   = v;
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] make_cast(input logic [COL_W-1:0] col,
                                                     input logic [PPOS_W-1:0] px,
                                                     input logic [PPOS_W-1:0] py,
                                                     input logic [ANG_W-1:0] pa);
    logic [IN_DATA_W-1:0] d;
    d = {$urandom, $urandom} & USED_MASK;
    d[IN_COL_LSB +: COL_W] = col;
    d[IN_PX_LSB +: PPOS_W] = px;
    d[IN_PY_LSB +: PPOS_W] = py;
    d[IN_PA_LSB +: ANG_W]  = pa;
    return d;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    board.take_request(kind, d);
  endtask

  // hold the sender until every strip is back and the core has gone quiet
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (board.strips_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [FOV_W-1:0] f, input logic [MAXD_W-1:0] m,
                            input logic [STEP_W-1:0] s);
    logic [REG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_FOV, REG_MAXD, REG_STEP, REG_NONE};
    val = '{CFG_DATA_W'(f), CFG_DATA_W'(m), CFG_DATA_W'(s), CFG_DATA_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      board.set_reg(idx[i], val[i]);
    end
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_strip(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no request or strip moved for %0d cycles", QUIET_LIMIT);
    $display("** grid_ray_march_column_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int fov_v, maxd_v, step_v, pick;
    logic [CELL_W-1:0] value;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_config(FOV_RESET, MAXD_RESET, STEP_RESET);

    // corner cells, overwrite to empty, percent-glyph wall cell in row 6
    send_request(KIND_WRITE, make_write(4'd0, 4'd0, 8'hFF));
    send_request(KIND_WRITE, make_write(4'd15, 4'd15, 8'hFF));
    send_request(KIND_WRITE, make_write(4'd8, 4'd8, 8'd2));
    send_request(KIND_WRITE, make_write(4'd8, 4'd8, 8'd0));
    send_request(KIND_WRITE, make_write(4'd12, 4'd6, 8'd2));
    send_request(KIND_CAST, make_cast(7'd64, 12'd640, 12'd1664, 10'd0));
    send_request(KIND_CAST, make_cast(7'd0, 12'd640, 12'd1664, 10'd0));
    send_request(KIND_CAST, make_cast(7'd127, 12'd640, 12'd1664, 10'd0));
    send_request(KIND_CAST, make_cast(7'd64, 12'd0, 12'd0, 10'd0));
    send_request(KIND_CAST, make_cast(7'd64, 12'd4095, 12'd2048, 10'd1023));
    send_request(KIND_CAST, make_cast(7'd64, 12'd256, 12'd768, 10'd512));
    send_request(KIND_CAST, make_cast(7'd64, 12'd1024, 12'd200, 10'd768));
    send_request(KIND_CAST, make_cast(7'd64, 12'd1024, 12'd1024, 10'd256));

    // zero march limit and zero step
    hold_until_drained();
    set_config(9'd1, 16'd0, 8'd0);
    send_request(KIND_CAST, make_cast(7'd0, 12'd2048, 12'd2048, 10'd100));
    send_request(KIND_CAST, make_cast(7'd127, 12'd2048, 12'd2048, 10'd900));

    // widest view, longest limit, unit step
    hold_until_drained();
    set_config(9'd511, 16'hFFFF, 8'd0);
    send_request(KIND_CAST, make_cast(7'd0, 12'd2048, 12'd2048, 10'd100));
    send_request(KIND_CAST, make_cast(7'd127, 12'd1500, 12'd2600, 10'd700));

    for (int b = 0; b < BLOCKS; b++) begin
      hold_until_drained();
      src_idle_pct   = (b < 3) ? 9 : (b < 6) ? 70 : 0;
      sink_stall_pct = (b < 3) ? 70 : (b < 6) ? 9 : 0;
      step_v = $urandom_range(255, 4);
      fov_v  = $urandom_range(511, 1);
      if ($urandom_range(3) == 0)
        maxd_v = $urandom_range(1024, 1);
      else
        maxd_v = $urandom_range((step_v * 400 > 65535) ? 65535 : step_v * 400, 1024);
      case (b)
        0: set_config(FOV_RESET, MAXD_RESET, STEP_RESET);
        1: set_config(9'd511, 16'hFFFF, 8'd255);
        2: set_config(9'd1, MAXD_W'($urandom_range(1024, 256)), 8'd1);
        default: set_config(FOV_W'(fov_v), MAXD_W'(maxd_v), STEP_W'(step_v));
      endcase
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if ($urandom_range(149) == 0) hold_until_drained();
        if ($urandom_range(99) < 35) begin
          pick = $urandom_range(99);
          value = (pick < 70) ? CELL_W'(0) : (pick < 82) ? CELL_W'(GLYPH_TYPE) :
                  CELL_W'($urandom_range(255, 1));
          send_request(KIND_WRITE, make_write(CELL_X_W'($urandom), CELL_Y_W'($urandom), value));
        end else begin
          send_request(KIND_CAST, make_cast(COL_W'($urandom), PPOS_W'($urandom),
                                            PPOS_W'($urandom), ANG_W'($urandom)));
        end
      end
    end

    hold_until_drained();
    $display("covered %0d map writes and %0d column casts under %0d register settings",
             board.n_writes, board.n_casts, n_settings);
    $display("strips: %0d walls (%0d percent glyph), %0d off the map, %0d open",
             board.n_walls, board.n_glyphs, board.n_outside, board.n_open);
    if (board.mismatches == 0 && board.strips_due.size() == 0) begin
      $display("** grid_ray_march_column_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d strips missing", board.mismatches,
               board.strips_due.size());
      $display("** grid_ray_march_column_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
